FILE: sv/skf_pkg.sv
// Shared types, command codes and the scan-code set 1 to ASCII table
// for the scancode key FIFO. No dependencies.
package skf_pkg;

  // Command codes carried in the request's cmd field.
  localparam logic CmdEvent = 1'b0;
  localparam logic CmdRead  = 1'b1;

  localparam int unsigned CodeW  = 8;
  localparam int unsigned CharW  = 7;
  localparam int unsigned CountW = 5;

  typedef struct packed {
    logic             cmd;
    logic             status_ready;
    logic [CodeW-1:0] scan_code;
  } req_t;

  typedef struct packed {
    logic [CharW-1:0]  key_char;
    logic              key_valid;
    logic              buffer_empty;
    logic              buffer_full;
    logic [CountW-1:0] keys_buffered;
  } rsp_t;

  // Make code (bit 7 clear) to ASCII; unmapped codes give 0.
  function automatic logic [CharW-1:0] set1_ascii(input logic [CharW-1:0] code);
    logic [CharW-1:0] ch;
    case (code)
      7'd2:    ch = 7'h31; // 1
      7'd3:    ch = 7'h32;
      7'd4:    ch = 7'h33;
      7'd5:    ch = 7'h34;
      7'd6:    ch = 7'h35;
      7'd7:    ch = 7'h36;
      7'd8:    ch = 7'h37;
      7'd9:    ch = 7'h38;
      7'd10:   ch = 7'h39;
      7'd11:   ch = 7'h30; // 0
      7'd12:   ch = 7'h2D; // -
      7'd13:   ch = 7'h3D; // =
      7'd14:   ch = 7'h08; // backspace
      7'd15:   ch = 7'h09; // tab
      7'd16:   ch = 7'h71; // q
      7'd17:   ch = 7'h77;
      7'd18:   ch = 7'h65;
      7'd19:   ch = 7'h72;
      7'd20:   ch = 7'h74;
      7'd21:   ch = 7'h79;
      7'd22:   ch = 7'h75;
      7'd23:   ch = 7'h69;
      7'd24:   ch = 7'h6F;
      7'd25:   ch = 7'h70;
      7'd26:   ch = 7'h5B; // [
      7'd27:   ch = 7'h5D; // ]
      7'd28:   ch = 7'h0A; // enter -> newline
      7'd30:   ch = 7'h61; // a
      7'd31:   ch = 7'h73;
      7'd32:   ch = 7'h64;
      7'd33:   ch = 7'h66;
      7'd34:   ch = 7'h67;
      7'd35:   ch = 7'h68;
      7'd36:   ch = 7'h6A;
      7'd37:   ch = 7'h6B;
      7'd38:   ch = 7'h6C;
      7'd39:   ch = 7'h3B; // ;
      7'd40:   ch = 7'h27; // quote
      7'd41:   ch = 7'h60; // backtick
      7'd43:   ch = 7'h5C; // backslash
      7'd44:   ch = 7'h7A; // z
      7'd45:   ch = 7'h78;
      7'd46:   ch = 7'h63;
      7'd47:   ch = 7'h76;
      7'd48:   ch = 7'h62;
      7'd49:   ch = 7'h6E;
      7'd50:   ch = 7'h6D;
      7'd51:   ch = 7'h2C; // ,
      7'd52:   ch = 7'h2E; // .
      7'd53:   ch = 7'h2F; // /
      7'd57:   ch = 7'h20; // space
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

FILE: sv/skf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/scancode_key_fifo_unit.sv
// Top level of the scancode key FIFO: request control, pointers and result register.
// Depends on skf_pkg and skf_ram.
//
// Keyboard front end with a character ring buffer. Each request is either a
// controller event (cmd = CmdEvent) or a read (cmd = CmdRead), and each gives
// exactly one result carrying the buffer status after that request. An event
// with status_ready set and a make code (scan_code bit 7 clear) is translated
// through the scan-code set 1 table and pushed; unmapped codes push 0. Break
// codes, events without status_ready and pushes into a full buffer leave the
// buffer unchanged. A read of an empty buffer returns key_char 0, key_valid 0.
// Timing: an event or an empty read is done at the accepting edge, its result
// registered there. A read that pops passes through the StRdata state, as the
// character RAM has registered read data; no new request is taken in StRdata.
// A new request is accepted while the previous result is being taken in the
// same cycle. Reset needs no clearing pass: only written entries are ever
// read. keys_buffered shows the count modulo 32.
module scancode_key_fifo_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  skf_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output skf_pkg::rsp_t out_rsp_o
);

  import skf_pkg::*;

  localparam int unsigned PtrW    = $clog2(DEPTH);
  localparam int unsigned CntW    = $clog2(DEPTH + 1);
  localparam int unsigned CntExtW = CntW + CountW;

  typedef enum logic [1:0] {
    StIdle  = 2'b01,  // ready for a request
    StRdata = 2'b10   // popped character on its way out of the RAM
  } state_e;

  state_e state_q, state_d;

  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;

  logic             accept;
  logic             is_full, is_empty;
  logic             push, pop;
  logic [CharW-1:0] push_char;
  logic [CharW-1:0] ram_rdata;
  logic             full_nxt;
  logic [CntExtW-1:0] count_ext;

  // Take a request only in idle, and only if the result slot is free now
  // or is being emptied at this edge.
  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);

  assign push = accept && (in_req_i.cmd == CmdEvent) && in_req_i.status_ready &&
                !in_req_i.scan_code[CodeW-1] && !is_full;
  assign pop  = accept && (in_req_i.cmd == CmdRead) && !is_empty;

  assign push_char = set1_ascii(in_req_i.scan_code[CharW-1:0]);

  skf_ram #(
    .Width (CharW),
    .Depth (DEPTH)
  ) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wr_ptr_q),
    .wdata_i (push_char),
    .re_i    (pop),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // Pointers wrap at DEPTH, which need not be a power of two.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      count_d  = count_q + 1'b1;
    end else if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      count_d  = count_q - 1'b1;
    end
  end

  assign full_nxt  = (count_d == CntW'(DEPTH));
  assign count_ext = CntExtW'(count_d);

  // Result register. Status fields are loaded at acceptance; a popping read
  // fills key_char and raises valid in the following cycle from the RAM output.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (accept) begin
          out_d.key_char      = '0;
          out_d.key_valid     = pop;
          out_d.buffer_empty  = (count_d == '0);
          out_d.buffer_full   = full_nxt;
          out_d.keys_buffered = count_ext[CountW-1:0];
          if (pop) begin
            state_d = StRdata;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      StRdata: begin
        out_d.key_char = ram_rdata;
        out_valid_d    = 1'b1;
        state_d        = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
